[rtl/core/ntcf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcf_pkg
// Shared types and constants of the numeric token character filter.
// ----------------------------------------------------------------------------
package ntcf_pkg;

    localparam int CP_W    = 21;
    localparam int WIDTH_W = 12;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int LEAD_W  = 2;

    localparam logic [WIDTH_W-1:0] WIDTH_UNSPEC = 12'hFFF;
    localparam logic [WIDTH_W-1:0] COUNT_MAX    = 12'hFFF;

    localparam logic [CP_W-1:0] CP_ZERO  = 21'h30;
    localparam logic [CP_W-1:0] CP_SEVEN = 21'h37;
    localparam logic [CP_W-1:0] CP_NINE  = 21'h39;
    localparam logic [CP_W-1:0] CP_DOT   = 21'h2E;
    localparam logic [CP_W-1:0] CP_PLUS  = 21'h2B;
    localparam logic [CP_W-1:0] CP_MINUS = 21'h2D;
    localparam logic [CP_W-1:0] CP_SPACE = 21'h20;
    localparam logic [CP_W-1:0] CP_TAB   = 21'h09;
    localparam logic [CP_W-1:0] CP_CR    = 21'h0D;
    localparam logic [CP_W-1:0] CP_UP_A  = 21'h41;
    localparam logic [CP_W-1:0] CP_UP_F  = 21'h46;
    localparam logic [CP_W-1:0] CP_LO_A  = 21'h61;
    localparam logic [CP_W-1:0] CP_LO_F  = 21'h66;
    localparam logic [CP_W-1:0] CP_LO_X  = 21'h78;
    localparam logic [CP_W-1:0] CP_LO_P  = 21'h70;
    localparam logic [CP_W-1:0] CP_LO_E  = 21'h65;
    localparam logic [CP_W-1:0] CP_CASE  = 21'h20;

    typedef enum logic [0:0] {
        CMD_OPEN = 1'b0,
        CMD_CHAR = 1'b1
    } command_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_DEC   = 3'd0,
        MODE_OCT   = 3'd1,
        MODE_HEX   = 3'd2,
        MODE_FLOAT = 3'd3,
        MODE_STR   = 3'd4,
        MODE_RAW   = 3'd5
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_KEPT     = 3'd0,
        ST_DROPPED  = 3'd1,
        ST_END_WS   = 3'd2,
        ST_END_EOI  = 3'd3,
        ST_NO_FIELD = 3'd4,
        ST_OPENED   = 3'd5
    } status_t;

    typedef enum logic [LEAD_W-1:0] {
        LEAD_NONE = 2'd0,
        LEAD_ZERO = 2'd1,
        LEAD_DONE = 2'd2
    } lead_t;

    typedef struct packed {
        logic not_hex;
        logic pre2;
        logic pre1;
        logic exp_sign;
        logic exp;
        logic point;
        logic sign;
    } syntax_flags_t;

    typedef struct packed {
        logic is_space;
        logic is_sign;
        logic is_digit;
        logic is_octal;
        logic is_xdigit;
        logic is_zero;
        logic is_dot;
        logic is_x;
        logic is_p;
        logic is_e;
    } char_class_t;

    typedef struct packed {
        status_t            status;
        logic [CP_W-1:0]    kept_char;
        logic [WIDTH_W-1:0] kept_count;
        logic               field_done;
        logic               success;
    } result_t;

endpackage

[rtl/core/ntcf_char_class.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcf_char_class
// Decodes one code point into the character classes used by the filter.
// ----------------------------------------------------------------------------
module ntcf_char_class
    import ntcf_pkg::*;
(
    input  logic [CP_W-1:0] code_point,
    output char_class_t     char_class
);

    always_comb begin
        char_class.is_space  = (code_point == CP_SPACE) ||
                               (code_point >= CP_TAB && code_point <= CP_CR);
        char_class.is_sign   = (code_point == CP_PLUS) || (code_point == CP_MINUS);
        char_class.is_digit  = (code_point >= CP_ZERO) && (code_point <= CP_NINE);
        char_class.is_octal  = (code_point >= CP_ZERO) && (code_point <= CP_SEVEN);
        char_class.is_xdigit = char_class.is_digit ||
                               (code_point >= CP_UP_A && code_point <= CP_UP_F) ||
                               (code_point >= CP_LO_A && code_point <= CP_LO_F);
        char_class.is_zero   = (code_point == CP_ZERO);
        char_class.is_dot    = (code_point == CP_DOT);
        char_class.is_x      = (code_point == CP_LO_X) || (code_point == CP_LO_X - CP_CASE);
        char_class.is_p      = (code_point == CP_LO_P) || (code_point == CP_LO_P - CP_CASE);
        char_class.is_e      = (code_point == CP_LO_E) || (code_point == CP_LO_E - CP_CASE);
    end

endmodule

[rtl/core/ntcf_scan_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcf_scan_core
// Field state and the per-character accept logic; produces one result per step.
// ----------------------------------------------------------------------------
module ntcf_scan_core
    import ntcf_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 4095
)
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  command_t           command,
    input  logic [MODE_W-1:0]  mode,
    input  logic [WIDTH_W-1:0] width,
    input  logic [CP_W-1:0]    code_point,
    input  logic               end_of_input,
    input  char_class_t        char_class,
    output result_t            result
);

    logic               field_open_reg, field_open_next;
    mode_t              mode_reg, mode_next;
    logic [WIDTH_W-1:0] limit_reg, limit_next;
    logic [WIDTH_W-1:0] kept_reg, kept_next;
    syntax_flags_t      flags_reg, flags_next;
    lead_t              lead_reg, lead_next;
    logic               any_kept_reg, any_kept_next;

    always_comb begin
        logic [WIDTH_W-1:0] width_adj;
        mode_t              mode_adj;
        syntax_flags_t      f;
        logic               accept;
        logic               done;

        field_open_next = field_open_reg;
        mode_next       = mode_reg;
        limit_next      = limit_reg;
        kept_next       = kept_reg;
        flags_next      = flags_reg;
        lead_next       = lead_reg;
        any_kept_next   = any_kept_reg;
        result          = '0;
        f               = flags_reg;
        accept          = 1'b0;
        done            = 1'b0;
        width_adj       = width;
        mode_adj        = MODE_STR;

        if (command == CMD_OPEN) begin
            if (mode <= MODE_RAW) begin
                mode_adj = mode_t'(mode);
            end
            if (mode_adj == MODE_RAW && width == WIDTH_UNSPEC) begin
                width_adj = WIDTH_W'(1);
            end
            if (32'(width_adj) > MAX_FIELD_WIDTH) begin
                width_adj = WIDTH_W'(MAX_FIELD_WIDTH);
            end
            mode_next         = mode_adj;
            limit_next        = width_adj;
            kept_next         = '0;
            flags_next        = '0;
            lead_next         = LEAD_NONE;
            any_kept_next     = 1'b0;
            field_open_next   = (width_adj != '0);
            result.status     = ST_OPENED;
            result.field_done = (width_adj == '0);
        end else if (!field_open_reg) begin
            result.status = ST_NO_FIELD;
        end else if (end_of_input) begin
            result.status     = ST_END_EOI;
            done              = 1'b1;
            result.kept_count = kept_reg;
            result.success    = any_kept_reg;
        end else if (mode_reg != MODE_RAW && char_class.is_space) begin
            result.status     = ST_END_WS;
            done              = 1'b1;
            result.kept_count = kept_reg;
            result.success    = any_kept_reg;
        end else begin
            unique case (mode_reg)
                MODE_DEC, MODE_OCT: begin
                    if (char_class.is_sign) begin
                        accept = !f.sign;
                        f.sign = 1'b1;
                    end else begin
                        accept = (mode_reg == MODE_DEC) ? char_class.is_digit
                                                        : char_class.is_octal;
                    end
                end
                MODE_HEX: begin
                    if (char_class.is_sign) begin
                        accept = !f.sign;
                        f.sign = 1'b1;
                    end else if (!f.pre1) begin
                        accept = char_class.is_zero;
                        f.pre1 = char_class.is_zero;
                    end else if (!f.pre2) begin
                        accept = char_class.is_x;
                        f.pre2 = char_class.is_x;
                    end else begin
                        accept = char_class.is_xdigit;
                    end
                end
                MODE_FLOAT: begin
                    if (!char_class.is_sign) begin
                        if (lead_reg == LEAD_NONE) begin
                            if (!char_class.is_zero) begin
                                f.not_hex = 1'b1;
                                lead_next = LEAD_DONE;
                            end else begin
                                lead_next = LEAD_ZERO;
                            end
                        end else if (lead_reg == LEAD_ZERO) begin
                            if (!char_class.is_x) begin
                                f.not_hex = 1'b1;
                            end
                            lead_next = LEAD_DONE;
                        end
                    end
                    if (char_class.is_sign) begin
                        if (f.exp) begin
                            accept     = !f.exp_sign;
                            f.exp_sign = 1'b1;
                        end else begin
                            accept = !f.sign;
                        end
                        f.sign = 1'b1;
                    end else if (!f.not_hex && !f.pre1) begin
                        accept = char_class.is_zero;
                        f.pre1 = char_class.is_zero;
                    end else if (!f.not_hex && !f.pre2) begin
                        accept = char_class.is_x;
                        f.pre2 = char_class.is_x;
                    end else if (char_class.is_dot) begin
                        accept  = !f.point;
                        f.point = 1'b1;
                    end else if (f.not_hex ? char_class.is_e : char_class.is_p) begin
                        accept = !f.exp;
                        f.exp  = 1'b1;
                    end else begin
                        accept = f.not_hex ? char_class.is_digit : char_class.is_xdigit;
                    end
                end
                default: begin
                    accept = 1'b1;
                end
            endcase
            flags_next = f;
            if (accept) begin
                if (kept_reg != COUNT_MAX) begin
                    kept_next = kept_reg + WIDTH_W'(1);
                end
                any_kept_next    = 1'b1;
                done             = (kept_next >= limit_reg);
                result.status    = ST_KEPT;
                result.kept_char = code_point;
            end else begin
                result.status = ST_DROPPED;
            end
            result.kept_count = kept_next;
            result.success    = any_kept_next;
        end

        if (done) begin
            field_open_next   = 1'b0;
            result.field_done = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_open_reg <= 1'b0;
            mode_reg       <= MODE_DEC;
            limit_reg      <= '0;
            kept_reg       <= '0;
            flags_reg      <= '0;
            lead_reg       <= LEAD_NONE;
            any_kept_reg   <= 1'b0;
        end else if (step_en) begin
            field_open_reg <= field_open_next;
            mode_reg       <= mode_next;
            limit_reg      <= limit_next;
            kept_reg       <= kept_next;
            flags_reg      <= flags_next;
            lead_reg       <= lead_next;
            any_kept_reg   <= any_kept_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        field_open_reg |-> (limit_reg != '0) && (kept_reg < limit_reg))
        else $error("open field has reached its limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && command == CMD_OPEN) |=> (kept_reg == '0) && !any_kept_reg)
        else $error("open did not clear the field count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (any_kept_reg == 1'b0) |-> (kept_reg == '0))
        else $error("kept count without a kept character");

endmodule

[rtl/core/numeric_token_char_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_token_char_filter
// Scanf-style token scanner that filters characters into a numeric field.
// ----------------------------------------------------------------------------
// The input stream carries one command per transfer. tuser selects opening a
// field (0, with mode and width in tdata) or presenting a character (1, with
// code_point in tdata, or end of input flagged on tlast). Every input transfer
// yields exactly one result transfer: the status on m_tuser, the kept
// character, kept count and success flag on m_tdata, and field_done on
// m_tlast.
// An input transfer is first captured in the input register. The filter logic
// and the field state update then load the result register, from which the
// result transfer is offered. Throughput is one transfer per cycle while the
// receiver does not stall.
// When the receiver stalls, the result register holds its transfer and the
// input register fills; s_tready then drops until the result is taken.
// Reset clears the valid flags of both registers and the field state, so no field is open.
// ----------------------------------------------------------------------------
module numeric_token_char_filter
    import ntcf_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 4095
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[2:0], width[14:3], code_point[35:15], zero fill
    input  logic [0:0]  s_tuser,   // command[0]
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // kept_char[20:0], kept_count[32:21], success[33], zero fill
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast    // field_done
);

    logic               in_valid_reg;
    command_t           in_cmd_reg;
    logic [MODE_W-1:0]  in_mode_reg;
    logic [WIDTH_W-1:0] in_width_reg;
    logic [CP_W-1:0]    in_cp_reg;
    logic               in_eoi_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               advance;
    logic               step_en;
    char_class_t        char_class;
    result_t            result;

    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_cmd_reg   <= command_t'(s_tuser[0]);
            in_mode_reg  <= s_tdata[2:0];
            in_width_reg <= s_tdata[14:3];
            in_cp_reg    <= s_tdata[35:15];
            in_eoi_reg   <= s_tlast;
        end
    end

    ntcf_char_class u_char_class (
        .code_point (in_cp_reg),
        .char_class (char_class)
    );

    ntcf_scan_core #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_scan_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (step_en),
        .command      (in_cmd_reg),
        .mode         (in_mode_reg),
        .width        (in_width_reg),
        .code_point   (in_cp_reg),
        .end_of_input (in_eoi_reg),
        .char_class   (char_class),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (step_en) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.field_done;
    assign m_tdata  = {6'd0, out_reg.success, out_reg.kept_count, out_reg.kept_char};

    assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> out_valid_reg)
        else $error("step taken without a result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.status == ST_KEPT) |->
            out_reg.success && (out_reg.kept_count != '0))
        else $error("kept result without success or count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_reg.status == ST_NO_FIELD || out_reg.status == ST_OPENED)) |->
            (out_reg.kept_count == '0) && !out_reg.success && (out_reg.kept_char == '0))
        else $error("open or no-field result carries data");

endmodule

[tb/ntcf_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntcf_result_checker
// Predicts and checks every result transfer of the numeric token filter.
// ----------------------------------------------------------------------------
// Each accepted input transfer is run through a local copy of the field
// scanner, which keeps its own mode, width limit, kept count, syntax flags and
// lead-character state. The predicted result is queued. Each accepted result
// transfer is compared field by field with the oldest prediction. The number
// of failures and the number of predictions still waiting are driven out.
// ----------------------------------------------------------------------------
module ntcf_result_checker
    import ntcf_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 4095
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // mode[2:0], width[14:3], code_point[35:15], zero fill
    input  logic [0:0]  s_tuser,   // command[0]
    input  logic        s_tlast,   // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // kept_char[20:0], kept_count[32:21], success[33], zero fill
    input  logic [2:0]  m_tuser,   // status[2:0]
    input  logic        m_tlast,   // field_done
    output int          fail_count,
    output int          outstanding
);

    localparam int PFX_REJECT = 0;
    localparam int PFX_TAKEN  = 1;
    localparam int PFX_DONE   = 2;

    bit                 field_open;
    mode_t              cur_mode;
    logic [WIDTH_W-1:0] char_limit;
    logic [WIDTH_W-1:0] kept_total;
    syntax_flags_t      flags;
    lead_t              lead;
    bit                 any_kept;

    result_t            predicted_results[$];
    result_t            want;
    result_t            seen;

    initial begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic bit is_space(logic [CP_W-1:0] c);
        return c == CP_SPACE || (c >= CP_TAB && c <= CP_CR);
    endfunction

    function automatic bit is_digit(logic [CP_W-1:0] c);
        return c >= CP_ZERO && c <= CP_NINE;
    endfunction

    function automatic bit is_xdigit(logic [CP_W-1:0] c);
        return is_digit(c) || (c >= CP_UP_A && c <= CP_UP_F) || (c >= CP_LO_A && c <= CP_LO_F);
    endfunction

    function automatic bit is_letter(logic [CP_W-1:0] c, logic [CP_W-1:0] lower);
        return c == lower || c == lower - CP_CASE;
    endfunction

    function automatic bit is_sign(logic [CP_W-1:0] c);
        return c == CP_PLUS || c == CP_MINUS;
    endfunction

    // In float mode a sign after the exponent mark is the exponent sign.
    function automatic bit sign_ok(bit float_rules);
        bit ok;
        if (float_rules && flags.exp) begin
            ok = !flags.exp_sign;
            flags.exp_sign = 1'b1;
        end else begin
            ok = !flags.sign;
        end
        flags.sign = 1'b1;
        return ok;
    endfunction

    function automatic int prefix_stage(logic [CP_W-1:0] c);
        if (!flags.pre1) begin
            if (c != CP_ZERO) return PFX_REJECT;
            flags.pre1 = 1'b1;
            return PFX_TAKEN;
        end
        if (!flags.pre2) begin
            if (!is_letter(c, CP_LO_X)) return PFX_REJECT;
            flags.pre2 = 1'b1;
            return PFX_TAKEN;
        end
        return PFX_DONE;
    endfunction

    function automatic bit char_accepted(logic [CP_W-1:0] c);
        int stage;
        bit ok;
        ok = 1'b0;
        case (cur_mode)
            MODE_DEC: begin
                if (is_sign(c)) ok = sign_ok(1'b0);
                else ok = is_digit(c);
            end
            MODE_OCT: begin
                if (is_sign(c)) ok = sign_ok(1'b0);
                else ok = c >= CP_ZERO && c <= CP_SEVEN;
            end
            MODE_HEX: begin
                if (is_sign(c)) begin
                    ok = sign_ok(1'b0);
                end else begin
                    stage = prefix_stage(c);
                    ok = (stage == PFX_DONE) ? is_xdigit(c) : (stage == PFX_TAKEN);
                end
            end
            MODE_FLOAT: begin
                if (!is_sign(c)) begin
                    if (lead == LEAD_NONE) begin
                        if (c != CP_ZERO) begin
                            flags.not_hex = 1'b1;
                            lead = LEAD_DONE;
                        end else begin
                            lead = LEAD_ZERO;
                        end
                    end else if (lead == LEAD_ZERO) begin
                        if (!is_letter(c, CP_LO_X)) flags.not_hex = 1'b1;
                        lead = LEAD_DONE;
                    end
                end
                if (is_sign(c)) begin
                    ok = sign_ok(1'b1);
                end else if (flags.not_hex) begin
                    if (c == CP_DOT) begin
                        ok = !flags.point;
                        flags.point = 1'b1;
                    end else if (is_letter(c, CP_LO_E)) begin
                        ok = !flags.exp;
                        flags.exp = 1'b1;
                    end else begin
                        ok = is_digit(c);
                    end
                end else begin
                    stage = prefix_stage(c);
                    if (stage != PFX_DONE) begin
                        ok = stage == PFX_TAKEN;
                    end else if (c == CP_DOT) begin
                        ok = !flags.point;
                        flags.point = 1'b1;
                    end else if (is_letter(c, CP_LO_P)) begin
                        ok = !flags.exp;
                        flags.exp = 1'b1;
                    end else begin
                        ok = is_xdigit(c);
                    end
                end
            end
            default: ok = 1'b1;
        endcase
        return ok;
    endfunction

    function automatic result_t scan_step(logic cmd, logic [MODE_W-1:0] md,
                                          logic [WIDTH_W-1:0] wd, logic [CP_W-1:0] cp,
                                          logic eoi);
        result_t            r;
        logic [MODE_W-1:0]  m;
        logic [WIDTH_W-1:0] w;
        r = '0;
        if (cmd == CMD_OPEN) begin
            m = md;
            w = wd;
            if (m > MODE_RAW) m = MODE_STR;
            if (m == MODE_RAW && w == WIDTH_UNSPEC) w = 12'd1;
            if (int'(w) > MAX_FIELD_WIDTH) w = WIDTH_W'(MAX_FIELD_WIDTH);
            cur_mode   = mode_t'(m);
            char_limit = w;
            kept_total = '0;
            flags      = '0;
            lead       = LEAD_NONE;
            any_kept   = 1'b0;
            field_open = w != '0;
            r.status     = ST_OPENED;
            r.field_done = w == '0;
            return r;
        end
        if (!field_open) begin
            r.status = ST_NO_FIELD;
            return r;
        end
        if (eoi) begin
            r.status     = ST_END_EOI;
            r.field_done = 1'b1;
        end else if (cur_mode != MODE_RAW && is_space(cp)) begin
            r.status     = ST_END_WS;
            r.field_done = 1'b1;
        end else if (char_accepted(cp)) begin
            r.status    = ST_KEPT;
            r.kept_char = cp;
            if (kept_total < COUNT_MAX) kept_total = kept_total + WIDTH_W'(1);
            any_kept = 1'b1;
            if (kept_total >= char_limit) r.field_done = 1'b1;
        end else begin
            r.status = ST_DROPPED;
        end
        if (r.field_done) field_open = 1'b0;
        r.kept_count = kept_total;
        r.success    = any_kept;
        return r;
    endfunction

    task automatic report_failure(string tag, result_t w, result_t s);
        if (fail_count < 10) begin
            $display("%s: expected status %0d char %h count %0d done %0b success %0b",
                     tag, w.status, w.kept_char, w.kept_count, w.field_done, w.success);
            $display("%s: actual   status %0d char %h count %0d done %0b success %0b",
                     tag, s.status, s.kept_char, s.kept_count, s.field_done, s.success);
        end
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            field_open = 1'b0;
            cur_mode   = MODE_DEC;
            char_limit = '0;
            kept_total = '0;
            flags      = '0;
            lead       = LEAD_NONE;
            any_kept   = 1'b0;
            predicted_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(scan_step(s_tuser[0], s_tdata[2:0], s_tdata[14:3],
                                                      s_tdata[35:15], s_tlast));
            end
            if (m_tvalid && m_tready) begin
                seen.status     = status_t'(m_tuser);
                seen.kept_char  = m_tdata[20:0];
                seen.kept_count = m_tdata[32:21];
                seen.field_done = m_tlast;
                seen.success    = m_tdata[33];
                if (predicted_results.size() == 0) begin
                    report_failure("unexpected result", '0, seen);
                end else begin
                    want = predicted_results.pop_front();
                    if (want.status !== seen.status || want.kept_char !== seen.kept_char ||
                        want.kept_count !== seen.kept_count ||
                        want.field_done !== seen.field_done || want.success !== seen.success) begin
                        report_failure("result mismatch", want, seen);
                    end
                end
            end
        end
        outstanding = predicted_results.size();
    end

endmodule

[tb/numeric_token_char_filter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_token_char_filter_tb
// Stimulus and verdict for the numeric token character filter.
// ----------------------------------------------------------------------------
// A short directed sequence covers every mode, the width extremes, the hex
// prefix, a hex float, an unused mode, zero width, reopening an open
// field, characters with no field and end of input. One string field of a
// hundred characters is then filled to its width. The random part opens fields
// with random mode and width and feeds mostly well-formed tokens with noise
// mixed in, ending them at whitespace, at end of input or not at all. Both
// sides idle at random, and the receiver holds off once for a long stretch so
// that the block stalls its input. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module numeric_token_char_filter_tb;
    import ntcf_pkg::*;

    localparam int             CYCLE_LIMIT   = 600000;
    localparam int             RANDOM_ITEMS  = 1270;
    localparam int             FILL_WIDTH    = 100;
    localparam int             HOLD_CYCLES   = 300;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] NEAR_MISS[10] = '{21'h08, 21'h0E, 21'h1F, 21'h2F, 21'h3A,
                                                   21'h40, 21'h47, 21'h67, 21'h38, 21'h39};

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    int fail_count;
    int outstanding;
    int sent_items  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit hold_req    = 1'b0;

    always #2 aclk = ~aclk;

    numeric_token_char_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    ntcf_result_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : receiver
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    task automatic send_item(input command_t cmd, input logic [MODE_W-1:0] md,
                             input logic [WIDTH_W-1:0] wd, input logic [CP_W-1:0] cp,
                             input logic eoi);
        while (!calm && $urandom_range(99) < 34) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, cp, wd, md};
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_items++;
    endtask

    function automatic logic [CP_W-1:0] any_cp();
        return CP_W'($urandom_range(0, CP_MAX));
    endfunction

    task automatic open_field(input logic [MODE_W-1:0] md, input logic [WIDTH_W-1:0] wd);
        send_item(CMD_OPEN, md, wd, any_cp(), 1'($urandom));
    endtask

    task automatic put_char(input logic [CP_W-1:0] cp, input logic eoi);
        send_item(CMD_CHAR, MODE_W'($urandom), WIDTH_W'($urandom), cp, eoi);
    endtask

    function automatic logic [CP_W-1:0] pick_space();
        return ($urandom_range(2) == 0) ? CP_SPACE : CP_W'($urandom_range(CP_TAB, CP_CR));
    endfunction

    function automatic logic [CP_W-1:0] pick_digit();
        return CP_ZERO + CP_W'($urandom_range(9));
    endfunction

    function automatic logic [CP_W-1:0] pick_xdigit();
        case ($urandom_range(2))
            0:       return pick_digit();
            1:       return CP_UP_A + CP_W'($urandom_range(5));
            default: return CP_LO_A + CP_W'($urandom_range(5));
        endcase
    endfunction

    function automatic logic [CP_W-1:0] pick_letter(logic [CP_W-1:0] lower);
        return $urandom_range(1) ? lower : lower - CP_CASE;
    endfunction

    function automatic logic [CP_W-1:0] pick_sign();
        return $urandom_range(1) ? CP_PLUS : CP_MINUS;
    endfunction

    function automatic logic [CP_W-1:0] noise_char();
        case ($urandom_range(5))
            0:       return pick_space();
            1:       return any_cp();
            2:       return CP_W'($urandom_range(8'h7F));
            3:       return NEAR_MISS[$urandom_range(9)];
            4: begin
                case ($urandom_range(2))
                    0:       return pick_letter(CP_LO_X);
                    1:       return pick_letter(CP_LO_E);
                    default: return pick_letter(CP_LO_P);
                endcase
            end
            default: return $urandom_range(1) ? pick_sign() : CP_DOT;
        endcase
    endfunction

    task automatic build_token(input logic [MODE_W-1:0] md, ref logic [CP_W-1:0] tok[$]);
        int n;
        tok.delete();
        n = $urandom_range(1, 6);
        case (md)
            MODE_DEC, MODE_OCT: begin
                if ($urandom_range(2) == 0) tok.push_back(pick_sign());
                repeat (n) begin
                    tok.push_back((md == MODE_OCT) ? CP_ZERO + CP_W'($urandom_range(7))
                                                   : pick_digit());
                end
            end
            MODE_HEX: begin
                if ($urandom_range(2) == 0) tok.push_back(pick_sign());
                tok.push_back(CP_ZERO);
                tok.push_back(pick_letter(CP_LO_X));
                repeat (n) tok.push_back(pick_xdigit());
            end
            MODE_FLOAT: begin
                if ($urandom_range(2) == 0) tok.push_back(pick_sign());
                if ($urandom_range(1)) begin
                    tok.push_back(CP_ZERO);
                    tok.push_back(pick_letter(CP_LO_X));
                    repeat (n) tok.push_back(pick_xdigit());
                    if ($urandom_range(1)) tok.push_back(CP_DOT);
                    repeat ($urandom_range(3)) tok.push_back(pick_xdigit());
                    if ($urandom_range(1)) begin
                        tok.push_back(pick_letter(CP_LO_P));
                        if ($urandom_range(1)) tok.push_back(pick_sign());
                        repeat ($urandom_range(1, 3)) tok.push_back(pick_digit());
                    end
                end else begin
                    repeat (n) tok.push_back(pick_digit());
                    if ($urandom_range(1)) tok.push_back(CP_DOT);
                    repeat ($urandom_range(3)) tok.push_back(pick_digit());
                    if ($urandom_range(1)) begin
                        tok.push_back(pick_letter(CP_LO_E));
                        if ($urandom_range(1)) tok.push_back(pick_sign());
                        repeat ($urandom_range(1, 3)) tok.push_back(pick_digit());
                    end
                end
            end
            default: begin
                repeat (n) begin
                    tok.push_back(($urandom_range(3) == 0) ? any_cp()
                                                           : CP_W'($urandom_range(8'h21, 8'h7E)));
                end
            end
        endcase
    endtask

    task automatic random_field();
        logic [CP_W-1:0]    tok[$];
        logic [MODE_W-1:0]  md;
        logic [WIDTH_W-1:0] wd;
        int                 roll;
        roll = $urandom_range(99);
        md = (roll < 8) ? MODE_W'(6 + $urandom_range(1)) : MODE_W'($urandom_range(int'(MODE_RAW)));
        roll = $urandom_range(99);
        if (roll < 15) wd = WIDTH_UNSPEC;
        else if (roll < 20) wd = WIDTH_W'($urandom);
        else if (roll < 23) wd = '0;
        else wd = WIDTH_W'($urandom_range(1, 12));
        open_field(md, wd);
        build_token(md, tok);
        foreach (tok[i]) begin
            if ($urandom_range(99) < 15) put_char(noise_char(), 1'b0);
            put_char(tok[i], 1'b0);
        end
        roll = $urandom_range(99);
        if (roll < 40) put_char(pick_space(), 1'b0);
        else if (roll < 70) put_char(any_cp(), 1'b1);
    endtask

    initial begin : stimulus
        int random_start;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        put_char(CP_NINE, 1'b0);
        open_field(MODE_DEC, WIDTH_UNSPEC);
        put_char(CP_PLUS, 1'b0);
        put_char(CP_MINUS, 1'b0);
        put_char(CP_NINE, 1'b0);
        put_char(CP_CR, 1'b0);
        open_field(MODE_OCT, 12'd2);
        put_char(CP_ZERO + 21'd8, 1'b0);
        put_char(CP_SEVEN, 1'b0);
        put_char(CP_ZERO, 1'b0);
        open_field(MODE_HEX, '0);
        open_field(MODE_HEX, WIDTH_UNSPEC);
        put_char(CP_ZERO, 1'b0);
        put_char(CP_LO_X - CP_CASE, 1'b0);
        put_char(CP_LO_F + 21'd1, 1'b0);
        put_char(CP_UP_F, 1'b0);
        put_char(CP_MAX, 1'b1);
        open_field(MODE_FLOAT, WIDTH_UNSPEC);
        put_char(CP_ZERO, 1'b0);
        put_char(CP_LO_X, 1'b0);
        put_char(CP_LO_P, 1'b0);
        put_char(CP_MINUS, 1'b0);
        put_char(CP_SPACE, 1'b0);
        open_field(3'd7, WIDTH_UNSPEC);
        put_char(CP_MAX, 1'b0);
        open_field(MODE_RAW, WIDTH_UNSPEC);
        put_char(CP_SPACE, 1'b0);
        put_char('0, 1'b1);

        open_field(MODE_STR, WIDTH_W'(FILL_WIDTH));
        repeat (FILL_WIDTH) put_char(CP_W'($urandom_range(8'h21, CP_MAX)), 1'b0);

        hold_req     <= 1'b1;
        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS) begin
            calm <= (sent_items - random_start >= 500) && (sent_items - random_start < 700);
            random_field();
        end
        s_tvalid <= 1'b0;
        calm     <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ntcf_pkg.sv
rtl/core/ntcf_char_class.sv
rtl/core/ntcf_scan_core.sv
rtl/core/numeric_token_char_filter.sv
tb/ntcf_result_checker.sv
tb/numeric_token_char_filter_tb.sv
